/* sv/slen_pkg.sv */
// Package for the sorted list engine.
// Holds command/result transaction types, mode and status codes, cell control types.
// No dependencies.
`default_nettype none

package slen_pkg;

  localparam int ValueW = 32;
  localparam int PosW   = 5;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_FIND   = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_DUMP   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] item_value;
    logic [PosW-1:0]          position;
    logic [PosW-1:0]          entry_total;
    logic                     last;
  } res_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_EVAL,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [ValueW-1:0] operand;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY,
    S_DUMP
  } state_t;

endpackage

`default_nettype wire

/* sv/slen_cell.sv */
// One storage cell of the sorted row: holds a value and its compare flags.
// Shifts with its neighbors on insert, remove and rotate. Depends on slen_pkg.
`default_nettype none

module slen_cell import slen_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  wire logic                     clk,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic [CW-1:0]            count,
  input  wire logic                     prev_lt,
  input  wire logic signed [ValueW-1:0] prev_value,
  input  wire logic signed [ValueW-1:0] next_value,
  input  wire logic signed [ValueW-1:0] head_value,
  output logic signed [ValueW-1:0]      value,
  output cell_flags_t                   flags
);

  localparam logic [CW-1:0] IDX     = CW'(INDEX);
  localparam logic [CW-1:0] IDX_INC = CW'(INDEX + 1);

  logic occupied;
  assign occupied = (IDX < count);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_EVAL: begin
        flags.lt <= occupied && (value < ctrl.operand);
        flags.eq <= occupied && (value == ctrl.operand);
      end
      CELL_INSERT: begin
        if (!flags.lt) begin
          value <= prev_lt ? ctrl.operand : prev_value;
        end
      end
      CELL_REMOVE: begin
        if (!flags.lt) begin
          value <= next_value;
        end
      end
      CELL_ROTATE: begin
        value <= (IDX_INC == count) ? head_value : next_value;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/slen_onehot_enc.sv */
// One-hot to binary index encoder for the boundary flags of the cell row.
// Depends on nothing but its parameters.
`default_nettype none

module slen_onehot_enc #(
  parameter int N  = 16,
  parameter int IW = 4
) (
  input  wire logic [N-1:0] onehot,
  output logic [IW-1:0]     index,
  output logic              any
);

  always_comb begin
    index = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        index = index | IW'(i);
      end
    end
  end

  assign any = |onehot;

endmodule

`default_nettype wire

/* sv/sorted_list_engine_unit.sv */
// Top level of the sorted list engine: controller, cell row and boundary encoder.
// Depends on slen_pkg, slen_cell and slen_onehot_enc.
//
//   channel  | ports                 | handshake
//   command  | cmd (cmd_t)           | start & !busy accepts a transaction
//   result   | result (res_t)        | done marks one result per cycle
//
// Insert, find, remove, clear: compare in S_EVAL, then S_APPLY shifts on insert or remove.
// Dump of n entries: n results on consecutive cycles, from S_DUMP after the compare;
// the row rotates through itself once and ends as it began.
// Reset clears the entry count and controller; stored values are kept as junk.
// The receiver cannot stall: results are never held back.
`default_nettype none

module sorted_list_engine_unit import slen_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output res_t      result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  state_t          state, state_next;
  cmd_t            op;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   dump_idx, dump_idx_next;
  logic            done_next;
  res_t            result_next;
  cell_ctrl_t      cell_ctrl;

  logic signed [ValueW-1:0] cell_value [CAPACITY];
  cell_flags_t              cell_flags [CAPACITY];
  logic [CAPACITY-1:0]      boundary;
  logic [CAPACITY-1:0]      hit;
  logic [IW-1:0]            bound_idx;
  logic                     bound_any;
  logic [CW-1:0]            pos;
  logic                     found;

  function automatic logic [PosW-1:0] to_pos(input logic [CW-1:0] x);
    logic [CW+PosW-1:0] wide;
    wide = {{PosW{1'b0}}, x};
    return wide[PosW-1:0];
  endfunction

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     prev_lt;
    logic signed [ValueW-1:0] prev_value;
    logic signed [ValueW-1:0] next_value;

    if (i == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_value = cmd.value;
    end else begin : g_mid
      assign prev_lt    = cell_flags[i-1].lt;
      assign prev_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_value = cell_value[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
    end

    slen_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .count      (count),
      .prev_lt    (prev_lt),
      .prev_value (prev_value),
      .next_value (next_value),
      .head_value (cell_value[0]),
      .value      (cell_value[i]),
      .flags      (cell_flags[i])
    );

    assign boundary[i] = prev_lt && !cell_flags[i].lt && (CW'(i) < count);
    assign hit[i]      = boundary[i] && cell_flags[i].eq;
  end

  slen_onehot_enc #(
    .N  (CAPACITY),
    .IW (IW)
  ) u_enc (
    .onehot (boundary),
    .index  (bound_idx),
    .any    (bound_any)
  );

  assign found = |hit;
  assign pos   = bound_any ? CW'(bound_idx) : count;
  assign busy  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      dump_idx <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_idx <= dump_idx_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op <= cmd;
    end
    result <= result_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    done_next     = 1'b0;
    result_next   = '0;
    cell_ctrl.op      = CELL_HOLD;
    cell_ctrl.operand = op.value;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cell_ctrl.op  = CELL_EVAL;
        dump_idx_next = '0;
        if (op.mode == MODE_DUMP && count != '0) begin
          state_next = S_DUMP;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        state_next       = S_IDLE;
        done_next        = 1'b1;
        result_next.last = 1'b1;
        result_next.entry_total = to_pos(count);
        case (op.mode)
          MODE_INSERT: begin
            if (count >= CAP) begin
              result_next.status = ST_FULL;
            end else begin
              cell_ctrl.op = CELL_INSERT;
              count_next   = count + CW'(1);
              result_next.position    = to_pos(pos);
              result_next.entry_total = to_pos(count + CW'(1));
            end
          end
          MODE_FIND: begin
            if (found) begin
              result_next.item_value = op.value;
              result_next.position   = to_pos(pos);
            end else begin
              result_next.status = ST_NOTFOUND;
            end
          end
          MODE_REMOVE: begin
            if (found) begin
              cell_ctrl.op = CELL_REMOVE;
              count_next   = count - CW'(1);
              result_next.position    = to_pos(pos);
              result_next.entry_total = to_pos(count - CW'(1));
            end else begin
              result_next.status = ST_NOTFOUND;
            end
          end
          MODE_CLEAR: begin
            count_next = '0;
            result_next.entry_total = '0;
          end
          MODE_DUMP: begin
            result_next.status = ST_EMPTY;
          end
          default: begin
          end
        endcase
      end
      S_DUMP: begin
        cell_ctrl.op  = CELL_ROTATE;
        done_next     = 1'b1;
        dump_idx_next = dump_idx + CW'(1);
        result_next.item_value  = cell_value[0];
        result_next.position    = to_pos(dump_idx);
        result_next.entry_total = to_pos(count);
        result_next.last        = (dump_idx == count - CW'(1));
        if (result_next.last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/slen_checker.sv */
// Port-level checker for the sorted list engine, bound to the top level.
// Depends on slen_pkg and sorted_list_engine_unit.
`default_nettype none

module slen_checker import slen_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire cmd_t cmd,
  input wire logic busy,
  input wire logic done,
  input wire res_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    done && result.last |=> !done)
    else $error("result strobe after final result");

  a_dump_burst: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |=> done)
    else $error("dump burst interrupted");

  a_burst_ok: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> result.status == ST_OK)
    else $error("non-final result without ok status");

  a_empty_dump: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_EMPTY |-> result.last && result.entry_total == '0)
    else $error("empty dump result malformed");

endmodule

bind sorted_list_engine_unit slen_checker u_slen_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .cmd    (cmd),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
